// File: design/bt1p_pkg.sv
`timescale 1ns / 1ps
// Package for the basic timer with one-pulse mode: widths, codes, register bits
// and the request/response structs. Depends on nothing.

package bt1p_pkg;

	localparam int COUNTER_WIDTH = 16;
	localparam int DATA_W        = 16;
	localparam int OP_W          = 2;
	localparam int SEL_W         = 3;
	localparam int CTRL_W        = 8;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	// register map
	typedef enum logic [SEL_W-1:0] {
		REG_CTRL  = 3'd0,
		REG_IER   = 3'd1,
		REG_STAT  = 3'd2,
		REG_EGR   = 3'd3,
		REG_CNT   = 3'd4,
		REG_PSC   = 3'd5,
		REG_ARR   = 3'd6
	} reg_sel_t;

	// control register bit positions
	localparam int CTL_EN   = 0;
	localparam int CTL_UDIS = 1;
	localparam int CTL_URS  = 2;
	localparam int CTL_OPM  = 3;
	localparam int CTL_ARPE = 7;
	localparam logic [CTRL_W-1:0] CTL_MASK = 8'h8F;

	typedef logic [COUNTER_WIDTH-1:0] cnt_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [SEL_W-1:0]  reg_select;
		logic [DATA_W-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              update_flag;
		logic              irq;
		logic              running;
	} rsp_t;

endpackage

// File: design/bt1p_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the timer: bus/tick requests and results.
// Depends on bt1p_pkg.

interface bt1p_req_if;
	logic                         valid;
	logic                         ready;
	logic [bt1p_pkg::OP_W-1:0]    operation;
	logic [bt1p_pkg::SEL_W-1:0]   reg_select;
	logic [bt1p_pkg::DATA_W-1:0]  write_data;

	modport source (output valid, output operation, output reg_select, output write_data,
		input ready);
	modport sink (input valid, input operation, input reg_select, input write_data,
		output ready);
endinterface

interface bt1p_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bt1p_pkg::DATA_W-1:0]  read_data;
	logic                         update_flag;
	logic                         irq;
	logic                         running;

	modport source (output valid, output read_data, output update_flag, output irq,
		output running, input ready);
	modport sink (input valid, input read_data, input update_flag, input irq,
		input running, output ready);
endinterface

// File: design/bt1p_core.sv
`timescale 1ns / 1ps
// Timer register file and next-state logic: one request is applied per strobe,
// the response reflects state after it. Depends on bt1p_pkg.

module bt1p_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             strobe,
	input  bt1p_pkg::req_t   req,
	output bt1p_pkg::rsp_t   rsp
);

	logic [bt1p_pkg::CTRL_W-1:0] ctrl_q, ctrl_n;
	logic                        ier_q, ier_n;
	logic                        flag_q, flag_n;
	bt1p_pkg::cnt_t              cnt_q, cnt_n;
	logic [bt1p_pkg::DATA_W-1:0] psc_cnt_q, psc_cnt_n;
	logic [bt1p_pkg::DATA_W-1:0] psc_pre_q, psc_pre_n;
	logic [bt1p_pkg::DATA_W-1:0] psc_act_q, psc_act_n;
	bt1p_pkg::cnt_t              arr_pre_q, arr_pre_n;
	bt1p_pkg::cnt_t              arr_act_q, arr_act_n;

	logic                        evt;
	logic                        evt_flag;
	logic                        upd_taken;
	logic [bt1p_pkg::DATA_W-1:0] rd;

	always_comb begin
		ctrl_n    = ctrl_q;
		ier_n     = ier_q;
		flag_n    = flag_q;
		cnt_n     = cnt_q;
		psc_cnt_n = psc_cnt_q;
		psc_pre_n = psc_pre_q;
		psc_act_n = psc_act_q;
		arr_pre_n = arr_pre_q;
		arr_act_n = arr_act_q;
		evt       = 1'b0;
		evt_flag  = 1'b0;
		rd        = '0;

		case (req.operation)
			bt1p_pkg::OP_TICK: begin
				if (ctrl_q[bt1p_pkg::CTL_EN]) begin
					if (psc_cnt_q < psc_act_q) begin
						psc_cnt_n = psc_cnt_q + 16'd1;
					end else begin
						psc_cnt_n = '0;
						if (arr_act_q != '0) begin
							if (cnt_q == arr_act_q) begin
								cnt_n    = '0;
								evt      = 1'b1;
								evt_flag = 1'b1;
							end else begin
								cnt_n = cnt_q + bt1p_pkg::cnt_t'(1);
							end
						end
					end
				end
			end
			bt1p_pkg::OP_READ: begin
				case (req.reg_select)
					bt1p_pkg::REG_CTRL: rd = bt1p_pkg::DATA_W'(ctrl_q);
					bt1p_pkg::REG_IER:  rd = bt1p_pkg::DATA_W'(ier_q);
					bt1p_pkg::REG_STAT: rd = bt1p_pkg::DATA_W'(flag_q);
					bt1p_pkg::REG_CNT:  rd = bt1p_pkg::DATA_W'(cnt_q);
					bt1p_pkg::REG_PSC:  rd = psc_pre_q;
					bt1p_pkg::REG_ARR:  rd = bt1p_pkg::DATA_W'(arr_pre_q);
					default:            rd = '0;
				endcase
			end
			bt1p_pkg::OP_WRITE: begin
				case (req.reg_select)
					bt1p_pkg::REG_CTRL: ctrl_n = req.write_data[7:0] & bt1p_pkg::CTL_MASK;
					bt1p_pkg::REG_IER:  ier_n  = req.write_data[0];
					bt1p_pkg::REG_STAT: begin
						if (!req.write_data[0]) flag_n = 1'b0;
					end
					bt1p_pkg::REG_EGR: begin
						if (req.write_data[0]) begin
							cnt_n     = '0;
							psc_cnt_n = '0;
							evt       = 1'b1;
							evt_flag  = !ctrl_q[bt1p_pkg::CTL_URS];
						end
					end
					bt1p_pkg::REG_CNT:  cnt_n     = bt1p_pkg::COUNTER_WIDTH'(req.write_data);
					bt1p_pkg::REG_PSC:  psc_pre_n = req.write_data;
					bt1p_pkg::REG_ARR: begin
						arr_pre_n = bt1p_pkg::COUNTER_WIDTH'(req.write_data);
						if (!ctrl_q[bt1p_pkg::CTL_ARPE])
							arr_act_n = bt1p_pkg::COUNTER_WIDTH'(req.write_data);
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		// update event: shadow load, flag, one-pulse stop (blocked by UDIS)
		upd_taken = evt && !ctrl_q[bt1p_pkg::CTL_UDIS];
		if (upd_taken) begin
			psc_act_n = psc_pre_q;
			arr_act_n = arr_pre_q;
			if (evt_flag) flag_n = 1'b1;
			if (ctrl_q[bt1p_pkg::CTL_OPM]) ctrl_n[bt1p_pkg::CTL_EN] = 1'b0;
		end

		rsp.read_data   = rd;
		rsp.update_flag = flag_n;
		rsp.irq         = flag_n & ier_n;
		rsp.running     = ctrl_n[bt1p_pkg::CTL_EN];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q    <= '0;
			ier_q     <= 1'b0;
			flag_q    <= 1'b0;
			cnt_q     <= '0;
			psc_cnt_q <= '0;
			psc_pre_q <= '0;
			psc_act_q <= '0;
			arr_pre_q <= '1;
			arr_act_q <= '1;
		end else if (strobe) begin
			ctrl_q    <= ctrl_n;
			ier_q     <= ier_n;
			flag_q    <= flag_n;
			cnt_q     <= cnt_n;
			psc_cnt_q <= psc_cnt_n;
			psc_pre_q <= psc_pre_n;
			psc_act_q <= psc_act_n;
			arr_pre_q <= arr_pre_n;
			arr_act_q <= arr_act_n;
		end
	end

	// reserved control bits never set
	a_ctrl_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q[6:4] == 3'b000)
		else $error("reserved control bits set");

	// one-pulse update stops the counter
	a_opm_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && upd_taken && ctrl_q[bt1p_pkg::CTL_OPM]) |=> !ctrl_q[bt1p_pkg::CTL_EN])
		else $error("one-pulse update left counter enabled");

	// taken update loads the shadows
	a_shadow_load: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && upd_taken) |=> (psc_act_q == $past(psc_pre_q) && arr_act_q == $past(arr_pre_q)))
		else $error("update event did not load shadows");

	// blocked update leaves flag alone
	a_udis: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && ctrl_q[bt1p_pkg::CTL_UDIS] && req.operation == bt1p_pkg::OP_TICK)
		|=> flag_q == $past(flag_q))
		else $error("flag changed while updates disabled");

endmodule

// File: design/basic_timer_with_one_pulse_unit.sv
`timescale 1ns / 1ps
// Top level of the basic timer with prescaler, auto-reload and one-pulse mode.
// Depends on bt1p_pkg, bt1p_if (req/rsp interfaces) and bt1p_core.
//
//  channel | dir | payload                                    | transaction
//  --------+-----+--------------------------------------------+----------------------
//  req     | in  | operation, reg_select, write_data          | tick, read or write
//  rsp     | out | read_data, update_flag, irq, running       | one per req
//
// Cycles: one transaction per clock unless rsp stalls; a request updates the timer
// state at the edge it is accepted and its response appears in the output
// register the next cycle. Throughput is set by the single response register:
// req.ready is high while that register is empty or being drained this cycle.
// Reset: arst_n clears the timer registers and the response valid; reload
// values reset to all ones. The response data register holds no reset.
// Stalls: while rsp is held, req.ready drops and no state changes.

module basic_timer_with_one_pulse_unit (
	input  logic        clk,
	input  logic        arst_n,
	bt1p_req_if.sink    req,
	bt1p_rsp_if.source  rsp
);

	logic           accept;
	bt1p_pkg::req_t core_req;
	bt1p_pkg::rsp_t core_rsp;
	logic           out_valid_q;
	bt1p_pkg::rsp_t out_data_q;

	// free output slot or slot emptying this cycle
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign core_req.operation  = req.operation;
	assign core_req.reg_select = req.reg_select;
	assign core_req.write_data = req.write_data;

	bt1p_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.strobe (accept),
		.req    (core_req),
		.rsp    (core_rsp)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= core_rsp;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_data   = out_data_q.read_data;
	assign rsp.update_flag = out_data_q.update_flag;
	assign rsp.irq         = out_data_q.irq;
	assign rsp.running     = out_data_q.running;

	// every accepted request yields a response next cycle
	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted request without response");

	// a pending response is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |-> !accept)
		else $error("request accepted over pending response");

	// irq is flag gated
	a_irq_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.irq) |-> out_data_q.update_flag)
		else $error("irq without update flag");

endmodule
